// ----- rtl/bcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants for the packed-BCD arithmetic unit
// Digit count, opcodes, status codes and request/result structs.
// ----------------------------------------------------------------------------
package bcd_pkg;

	localparam int DIGITS = 16;
	localparam int WORD_W = 64;
	localparam int DIG_W  = $clog2(DIGITS);
	localparam int DCNT_W = $clog2(DIGITS + 1);

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_OVF    = 3'd1;
	localparam logic [2:0] ST_NEG    = 3'd2;
	localparam logic [2:0] ST_DIVZ   = 3'd3;
	localparam logic [2:0] ST_BADDIG = 3'd4;

	typedef struct packed {
		logic [2:0]        op;
		logic [WORD_W-1:0] a_value;
		logic [WORD_W-1:0] b_value;
	} bcd_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_value;
		logic [2:0]        status;
		logic              a_less;
		logic              a_equal;
	} bcd_rsp_t;

	// Digit adder result: one BCD digit and a carry
	typedef struct packed {
		logic       carry;
		logic [3:0] digit;
	} dsum_t;

endpackage

// ----- rtl/bcd_decimal_alu.sv -----
// ----------------------------------------------------------------------------
// bcd_decimal_alu: packed-BCD add, subtract, multiply, divide and compare
// A sequencer drives one shared digit adder, one digit per cycle.
// ----------------------------------------------------------------------------
//  channel | direction | payload            | handshake
//  req     | in        | bcd_req_t          | req_valid / req_ready
//  rsp     | out       | bcd_rsp_t          | rsp_valid / rsp_ready
//
// Each pass runs one digit per cycle through the shared digit adder, over D digits
// for compare/add/sub, 2*DIGITS+1 digits for a multiply pass and DIGITS+1 for a divide trial.
// Add/sub: a compare pass, then an add/sub pass; compare: the compare pass only.
// Multiply: per multiplier digit up to nine shifted additions of 2*DIGITS+1 digits.
// Divide: per quotient digit up to ten trial subtractions of D+1 digits.
// Reset clears the sequencer; one request is worked on at a time. A finished
// result waits in the work register until the output register is free, so a
// stalled output holds at most one result in the output register and one in the work register.
module bcd_decimal_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bcd_pkg::bcd_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bcd_pkg::bcd_rsp_t rsp
);

	localparam int D  = bcd_pkg::DIGITS;
	localparam int PW = 4 * (2 * D + 1); // product / remainder accumulator
	localparam int AW = $clog2(2 * D + 2);
	localparam int DIG_W_L = bcd_pkg::DCNT_W;
	localparam int WORD_W_C = bcd_pkg::WORD_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CMP  = 3'd1;
	localparam logic [2:0] S_ARTH = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]        state_q;
	logic [2:0]        op_q;
	logic [4*D-1:0]    a_q, b_q;
	logic [PW-1:0]     acc_q;   // product, or remainder in divide
	logic [PW-1:0]     tmp_q;   // shift register of the pass result
	logic [4*D-1:0]    quo_q;   // quotient, or multiplier digits
	logic [AW-1:0]     pos_q;   // digit position in a pass
	logic [DIG_W_L-1:0] dig_q;  // outer digit index
	logic [3:0]        cnt_q;   // repetition count within a digit
	logic              cy_q;
	logic              rsp_valid_q;
	bcd_pkg::bcd_rsp_t res_q;   // result being built
	bcd_pkg::bcd_rsp_t rsp_q;

	// Shared digit unit inputs
	logic           u_sub;
	logic [3:0]     u_x, u_y;
	bcd_pkg::dsum_t u_s;

	bcd_digit_unit u_dig (
		.sub(u_sub), .x(u_x), .y(u_y), .cin(cy_q), .sum(u_s)
	);

	// Validity of used nibbles
	logic bad_a, bad_b;
	always_comb begin
		bad_a = 1'b0;
		bad_b = 1'b0;
		for (int i = 0; i < D; i++) begin
			if (req.a_value[4*i +: 4] > 4'd9) bad_a = 1'b1;
			if (req.b_value[4*i +: 4] > 4'd9) bad_b = 1'b1;
		end
	end

	logic [AW-1:0] pass_len;
	logic          pass_end;
	logic          b_zero;
	logic [3:0]    mdig;
	logic [AW-1:0] div_len;

	assign b_zero  = (b_q == '0);
	assign mdig    = quo_q[4*D-1 -: 4];
	assign div_len = AW'(D + 1);

	// Select operands for the shared unit
	always_comb begin
		u_sub    = 1'b1;
		u_x      = 4'd0;
		u_y      = 4'd0;
		pass_len = AW'(D);
		case (state_q)
			S_CMP: begin
				u_x = a_q[4*pos_q[DIG_W_L-1:0] +: 4];
				u_y = b_q[4*pos_q[DIG_W_L-1:0] +: 4];
			end
			S_ARTH: begin
				u_sub = (op_q != bcd_pkg::OP_ADD);
				u_x   = a_q[4*pos_q[DIG_W_L-1:0] +: 4];
				u_y   = b_q[4*pos_q[DIG_W_L-1:0] +: 4];
			end
			S_MUL: begin
				// acc += b shifted by dig_q, over 2D+1 digits
				u_sub    = 1'b0;
				pass_len = AW'(2 * D + 1);
				u_x      = acc_q[4*pos_q +: 4];
				if ((pos_q >= AW'(dig_q)) && (pos_q < AW'(dig_q) + AW'(D)))
					u_y = b_q[4*(pos_q - AW'(dig_q)) +: 4];
			end
			S_DIV: begin
				// trial: rem(D+1 digits) - b
				pass_len = div_len;
				u_x      = acc_q[4*pos_q +: 4];
				if (pos_q < AW'(D)) u_y = b_q[4*pos_q[DIG_W_L-1:0] +: 4];
			end
			default: ;
		endcase
	end

	assign pass_end = (pos_q == pass_len - AW'(1));

	logic [PW-1:0] tmp_nx;
	assign tmp_nx = {u_s.digit, tmp_q[PW-1:4]};

	logic [PW-1:0] pass_res; // tmp after final shift, aligned to digit 0
	assign pass_res = tmp_nx >> (4 * (2 * D + 1) - 4 * int'(pass_len));

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			cy_q        <= 1'b0;
			pos_q       <= '0;
		end else begin
			// Output register: load when empty or being taken
			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res_q;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q  <= req.op;
						a_q   <= req.a_value[4*D-1:0];
						b_q   <= req.b_value[4*D-1:0];
						cy_q  <= 1'b0;
						pos_q <= '0;
						if (bad_a || bad_b) begin
							res_q.result_value <= '0;
							res_q.status       <= bcd_pkg::ST_BADDIG;
							res_q.a_less       <= 1'b0;
							res_q.a_equal      <= 1'b0;
							state_q            <= S_DONE;
						end else begin
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					// a - b: borrow out means a < b
					cy_q  <= u_s.carry;
					tmp_q <= tmp_nx;
					pos_q <= pos_q + AW'(1);
					if (pass_end) begin
						cy_q   <= 1'b0;
						pos_q  <= '0;
						res_q.result_value <= '0;
						res_q.status       <= bcd_pkg::ST_OK;
						res_q.a_less       <= u_s.carry;
						res_q.a_equal      <= (a_q == b_q);
						acc_q <= '0;
						dig_q <= '0;
						cnt_q <= '0;
						quo_q <= (op_q == bcd_pkg::OP_MUL) ? a_q : '0;
						case (op_q)
							bcd_pkg::OP_ADD: state_q <= S_ARTH;
							bcd_pkg::OP_SUB: begin
								if (u_s.carry) begin
									res_q.status <= bcd_pkg::ST_NEG;
									state_q      <= S_DONE;
								end else state_q <= S_ARTH;
							end
							bcd_pkg::OP_MUL: begin
								dig_q <= DIG_W_L'(D - 1);
								state_q <= S_MUL;
							end
							bcd_pkg::OP_DIV: begin
								if (b_zero) begin
									res_q.status <= bcd_pkg::ST_DIVZ;
									state_q      <= S_DONE;
								end else begin
									dig_q   <= DIG_W_L'(D - 1);
									acc_q   <= PW'(a_q[4*D-1 -: 4]);
									state_q <= S_DIV;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ARTH: begin
					cy_q  <= u_s.carry;
					tmp_q <= tmp_nx;
					pos_q <= pos_q + AW'(1);
					if (pass_end) begin
						res_q.result_value <= WORD_W_C'(pass_res[4*D-1:0]);
						if (op_q == bcd_pkg::OP_ADD && u_s.carry)
							res_q.status <= bcd_pkg::ST_OVF;
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					// top multiplier digit first; digit weight comes from shifting b by dig_q
					if (cnt_q == mdig) begin
						// next digit
						cnt_q <= '0;
						pos_q <= '0;
						cy_q  <= 1'b0;
						quo_q <= {quo_q[4*D-5:0], 4'd0};
						if (dig_q == '0) begin
							res_q.result_value <= WORD_W_C'(acc_q[4*D-1:0]);
							if (acc_q[PW-1:4*D] != '0) res_q.status <= bcd_pkg::ST_OVF;
							state_q <= S_DONE;
						end else dig_q <= dig_q - DIG_W_L'(1);
					end else begin
						cy_q  <= u_s.carry;
						tmp_q <= tmp_nx;
						pos_q <= pos_q + AW'(1);
						if (pass_end) begin
							acc_q <= pass_res;
							cy_q  <= 1'b0;
							pos_q <= '0;
							cnt_q <= cnt_q + 4'd1;
						end
					end
				end
				S_DIV: begin
					cy_q  <= u_s.carry;
					tmp_q <= tmp_nx;
					pos_q <= pos_q + AW'(1);
					if (pass_end) begin
						cy_q  <= 1'b0;
						pos_q <= '0;
						if (!u_s.carry) begin
							acc_q <= pass_res;
							cnt_q <= cnt_q + 4'd1;
						end else begin
							quo_q <= {quo_q[4*D-5:0], cnt_q};
							cnt_q <= '0;
							if (dig_q == '0) begin
								res_q.result_value <=
									WORD_W_C'({quo_q[4*D-5:0], cnt_q});
								state_q <= S_DONE;
							end else begin
								dig_q <= dig_q - DIG_W_L'(1);
								acc_q <= PW'({acc_q[4*D-1:0],
									a_q[4*(dig_q - DIG_W_L'(1)) +: 4]});
							end
						end
					end
				end
				S_DONE: begin
					// hand over once the output register is free
					if (!rsp_valid_q || rsp_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/bcd_digit_unit.sv -----
// ----------------------------------------------------------------------------
// bcd_digit_unit: shared decimal digit adder/subtractor
// One digit plus (or minus) one digit plus an incoming carry (or borrow).
// ----------------------------------------------------------------------------
module bcd_digit_unit (
	input  logic          sub,
	input  logic [3:0]    x,
	input  logic [3:0]    y,
	input  logic          cin,
	output bcd_pkg::dsum_t sum
);

	logic [4:0] raw;

	// Binary add/sub then decimal correction
	always_comb begin
		if (sub) begin
			raw = {1'b0, x} - {1'b0, y} - {4'd0, cin};
			if (raw[4]) begin
				sum.digit = 4'(raw[3:0] + 4'd10);
				sum.carry = 1'b1;
			end else begin
				sum.digit = raw[3:0];
				sum.carry = 1'b0;
			end
		end else begin
			raw = {1'b0, x} + {1'b0, y} + {4'd0, cin};
			if (raw > 5'd9) begin
				sum.digit = 4'(raw - 5'd10);
				sum.carry = 1'b1;
			end else begin
				sum.digit = raw[3:0];
				sum.carry = 1'b0;
			end
		end
	end

endmodule

// ----- rtl/bcd_alu_checker.sv -----
// ----------------------------------------------------------------------------
// bcd_alu_checker: port-level checks for bcd_decimal_alu
// Watches the request/result handshakes and result codes.
// ----------------------------------------------------------------------------
module bcd_alu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input bcd_pkg::bcd_req_t req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input bcd_pkg::bcd_rsp_t rsp
);

	// A waiting result holds still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Status code in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= bcd_pkg::ST_BADDIG)
		else $error("bad status code");

	// Less and equal never both set
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.a_less && rsp.a_equal))
		else $error("less and equal both set");

	// Negative, divide-by-zero and bad-digit errors give a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == bcd_pkg::ST_NEG || rsp.status == bcd_pkg::ST_DIVZ
		|| rsp.status == bcd_pkg::ST_BADDIG) |-> rsp.result_value == '0)
		else $error("nonzero result on error");

	// One request at a time: taking a request drops ready next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after request");

endmodule

bind bcd_decimal_alu bcd_alu_checker u_chk (.*);

// ----- sim/tb_bcd_decimal_alu.sv -----
// ----------------------------------------------------------------------------
// tb_bcd_decimal_alu: self-checking testbench for the packed-BCD unit
// A directed table of corner cases, then random requests under three
// idling mixes. Results are checked against a local digit-level model or the table.
// ----------------------------------------------------------------------------
module tb_bcd_decimal_alu;
	timeunit 1ns;
	timeprecision 1ps;

	// opcodes the unit treats like compare
	localparam logic [2:0] OP_RES5 = 3'd5;
	localparam logic [2:0] OP_RES6 = 3'd6;
	localparam logic [2:0] OP_RES7 = 3'd7;

	localparam logic [63:0] MAXV = 64'h9999_9999_9999_9999;
	localparam int RAND_PER_PHASE = 200;
	localparam int STALL_LIMIT = 40000;
	localparam int HOLD_CYCLES = 400;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	bcd_pkg::bcd_req_t req;
	logic              rsp_valid;
	logic              rsp_ready;
	bcd_pkg::bcd_rsp_t rsp;

	bcd_pkg::bcd_rsp_t pending_rsp[$];
	int       errors;
	int       send_idle_pct;
	int       recv_idle_pct;
	bit       hold_go;
	int       hold_cnt;
	int       quiet_cycles;

	bcd_decimal_alu uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// digit-level model of one request
	function automatic bcd_pkg::bcd_rsp_t alu_model(bcd_pkg::bcd_req_t r);
		bcd_pkg::bcd_rsp_t o;
		bit [3:0]   da[16];
		bit [3:0]   db[16];
		bit         bad;
		bit [63:0]  a, b, m, x, s;
		int         p[32];
		int         carry, t;
		bit         ovf;
		o = '0;
		bad = 1'b0;
		a = 0; b = 0; m = 1;
		for (int i = 0; i < bcd_pkg::DIGITS; i++) begin
			da[i] = r.a_value[4*i +: 4];
			db[i] = r.b_value[4*i +: 4];
			if (da[i] > 9 || db[i] > 9) bad = 1'b1;
			m = m * 10;
		end
		if (bad) begin
			o.status = bcd_pkg::ST_BADDIG;
			return o;
		end
		for (int i = bcd_pkg::DIGITS - 1; i >= 0; i--) begin
			a = a * 10 + da[i];
			b = b * 10 + db[i];
		end
		o.a_less = (a < b);
		o.a_equal = (a == b);
		x = 0;
		case (r.op)
			bcd_pkg::OP_ADD: begin
				s = a + b;
				if (s >= m) begin
					s -= m;
					o.status = bcd_pkg::ST_OVF;
				end
				x = s;
			end
			bcd_pkg::OP_SUB: begin
				if (a < b) o.status = bcd_pkg::ST_NEG;
				else x = a - b;
			end
			bcd_pkg::OP_MUL: begin
				for (int i = 0; i < 32; i++) p[i] = 0;
				for (int i = 0; i < bcd_pkg::DIGITS; i++)
					for (int j = 0; j < bcd_pkg::DIGITS; j++)
						p[i+j] += da[i] * db[j];
				carry = 0;
				ovf = 1'b0;
				for (int i = 0; i < 2*bcd_pkg::DIGITS; i++) begin
					t = p[i] + carry;
					p[i] = t % 10;
					carry = t / 10;
					if (i >= bcd_pkg::DIGITS && p[i] != 0) ovf = 1'b1;
				end
				for (int i = bcd_pkg::DIGITS - 1; i >= 0; i--) x = x * 10 + p[i];
				if (ovf) o.status = bcd_pkg::ST_OVF;
			end
			bcd_pkg::OP_DIV: begin
				if (b == 0) o.status = bcd_pkg::ST_DIVZ;
				else x = a / b;
			end
			default: ;
		endcase
		for (int i = 0; i < bcd_pkg::DIGITS; i++) begin
			o.result_value[4*i +: 4] = 4'(x % 10);
			x = x / 10;
		end
		return o;
	endfunction

	// random operand: mostly short, some full width, a few bad nibbles
	function automatic logic [63:0] rand_bcd();
		logic [63:0] v;
		int          nd;
		v = '0;
		nd = ($urandom_range(99) < 70) ? $urandom_range(4, 1) : bcd_pkg::DIGITS;
		for (int i = 0; i < nd; i++) v[4*i +: 4] = 4'($urandom_range(9));
		if ($urandom_range(99) < 5)
			v[4*$urandom_range(bcd_pkg::DIGITS-1) +: 4] = 4'($urandom_range(15, 10));
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic idle_cycle();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	// offer one request; expectation is queued on acceptance
	task automatic send_req(bcd_pkg::bcd_req_t r, bcd_pkg::bcd_rsp_t want);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(want);
	endtask

	task automatic send_random(bit allow_idle);
		bcd_pkg::bcd_req_t r;
		while (allow_idle && $urandom_range(99) < send_idle_pct) idle_cycle();
		r.op = ($urandom_range(99) < 90) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
		r.a_value = rand_bcd();
		case ($urandom_range(9))
			0: r.b_value = r.a_value;
			1: r.b_value = '0;
			default: r.b_value = rand_bcd();
		endcase
		send_req(r, alu_model(r));
	endtask

	// response side: random ready, long hold on request, checking
	initial begin
		bcd_pkg::bcd_rsp_t want;
		rsp_ready = 1'b0;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("unexpected result", rsp.result_value, 64'd0);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.result_value !== want.result_value)
						report_mismatch("result_value", rsp.result_value, want.result_value);
					if (rsp.status !== want.status)
						report_mismatch("status", 64'(rsp.status), 64'(want.status));
					if (rsp.a_less !== want.a_less)
						report_mismatch("a_less", 64'(rsp.a_less), 64'(want.a_less));
					if (rsp.a_equal !== want.a_equal)
						report_mismatch("a_equal", 64'(rsp.a_equal), 64'(want.a_equal));
				end
			end
			if (hold_go) begin
				hold_go = 1'b0;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	typedef struct {
		bcd_pkg::bcd_req_t r;
		bit                typed;
		bcd_pkg::bcd_rsp_t want;
	} vec_row_t;

	vec_row_t directed[$];

	function automatic vec_row_t row(logic [2:0] op, logic [63:0] a, logic [63:0] b,
			bit typed = 0, logic [63:0] res = 0, logic [2:0] st = bcd_pkg::ST_OK,
			bit lt = 0, bit eq = 0);
		vec_row_t v;
		v.r = '{op: op, a_value: a, b_value: b};
		v.typed = typed;
		v.want = '{result_value: res, status: st, a_less: lt, a_equal: eq};
		return v;
	endfunction

	initial begin
		errors = 0;
		quiet_cycles = 0;
		hold_go = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		directed = '{
			row(bcd_pkg::OP_ADD, 0, 0, 1, 0, bcd_pkg::ST_OK, 0, 1),
			row(bcd_pkg::OP_ADD, MAXV, 1, 1, 0, bcd_pkg::ST_OVF, 0, 0),
			row(bcd_pkg::OP_ADD, MAXV, MAXV, 1, 64'h9999_9999_9999_9998,
				bcd_pkg::ST_OVF, 0, 1),
			row(bcd_pkg::OP_ADD, 64'h1234, 64'h8766),
			row(bcd_pkg::OP_SUB, 0, 1, 1, 0, bcd_pkg::ST_NEG, 1, 0),
			row(bcd_pkg::OP_SUB, MAXV, MAXV, 1, 0, bcd_pkg::ST_OK, 0, 1),
			row(bcd_pkg::OP_SUB, MAXV, 0, 1, MAXV, bcd_pkg::ST_OK, 0, 0),
			row(bcd_pkg::OP_SUB, 64'h1000, 64'h1),
			row(bcd_pkg::OP_MUL, 0, MAXV, 1, 0, bcd_pkg::ST_OK, 1, 0),
			row(bcd_pkg::OP_MUL, MAXV, MAXV),
			row(bcd_pkg::OP_MUL, 64'h9999, 64'h9999),
			row(bcd_pkg::OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000),
			row(bcd_pkg::OP_DIV, 64'h42, 0, 1, 0, bcd_pkg::ST_DIVZ, 0, 0),
			row(bcd_pkg::OP_DIV, MAXV, 1, 1, MAXV, bcd_pkg::ST_OK, 0, 0),
			row(bcd_pkg::OP_DIV, 1, MAXV, 1, 0, bcd_pkg::ST_OK, 1, 0),
			row(bcd_pkg::OP_DIV, MAXV, 64'h7),
			row(bcd_pkg::OP_CMP, 64'h5, 64'h7, 1, 0, bcd_pkg::ST_OK, 1, 0),
			row(bcd_pkg::OP_CMP, MAXV, MAXV, 1, 0, bcd_pkg::ST_OK, 0, 1),
			row(OP_RES5, 64'h9, 64'h3),
			row(OP_RES6, 64'h3, 64'h9),
			row(OP_RES7, MAXV, MAXV),
			row(bcd_pkg::OP_ADD, 64'hF000_0000_0000_0000, 1, 1, 0,
				bcd_pkg::ST_BADDIG, 0, 0),
			row(bcd_pkg::OP_MUL, 1, 64'h0000_0000_0000_000A, 1, 0,
				bcd_pkg::ST_BADDIG, 0, 0),
			row(bcd_pkg::OP_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 0,
				bcd_pkg::ST_BADDIG, 0, 0)
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (directed[i])
			send_req(directed[i].r,
				directed[i].typed ? directed[i].want : alu_model(directed[i].r));

		// random phases with different idling mixes
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 71 : 0;
			recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 33 : 0;
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (ph == 0 && n == 40) hold_go = 1'b1;
				if (ph == 1 && n == 100) begin
					req_valid <= 1'b0;
					while (pending_rsp.size() != 0) @(posedge clk);
				end
				send_random(1'b1);
			end
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/bcd_pkg.sv
rtl/bcd_digit_unit.sv
rtl/bcd_decimal_alu.sv
rtl/bcd_alu_checker.sv
sim/tb_bcd_decimal_alu.sv
